FILE: rtl/mr_pkg.sv
package mr_pkg;

   localparam int WIDTH_DEFAULT = 64;
   localparam int SMALL_PRIME_COUNT_DEFAULT = 167;
   localparam int PRIME_TABLE_LEN = 167;
   localparam int PRIME_IDX_W = 8;

   localparam logic [1:0] VERDICT_COMPOSITE = 2'd0;
   localparam logic [1:0] VERDICT_PRIME     = 2'd1;
   localparam logic [1:0] VERDICT_PROBABLE  = 2'd2;
   localparam logic [1:0] VERDICT_BAD_BASE  = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_TRIAL_LOAD,
      ST_TRIAL_RUN,
      ST_TRIAL_EVAL,
      ST_SPLIT,
      ST_POW_SQ,
      ST_POW_MUL,
      ST_POW_WAIT,
      ST_SQ_CHECK,
      ST_SQ_WAIT,
      ST_DONE
   } state_type;

   // Multiplier control into the modular multiplier.
   typedef struct packed {
      logic start;
   } mul_ctl_type;

   function automatic logic [9:0] odd_prime(input logic [PRIME_IDX_W-1:0] idx);
      logic [9:0] p;
      case (idx)
         8'd0: p = 10'd3;     8'd1: p = 10'd5;     8'd2: p = 10'd7;     8'd3: p = 10'd11;
         8'd4: p = 10'd13;    8'd5: p = 10'd17;    8'd6: p = 10'd19;    8'd7: p = 10'd23;
         8'd8: p = 10'd29;    8'd9: p = 10'd31;    8'd10: p = 10'd37;   8'd11: p = 10'd41;
         8'd12: p = 10'd43;   8'd13: p = 10'd47;   8'd14: p = 10'd53;   8'd15: p = 10'd59;
         8'd16: p = 10'd61;   8'd17: p = 10'd67;   8'd18: p = 10'd71;   8'd19: p = 10'd73;
         8'd20: p = 10'd79;   8'd21: p = 10'd83;   8'd22: p = 10'd89;   8'd23: p = 10'd97;
         8'd24: p = 10'd101;  8'd25: p = 10'd103;  8'd26: p = 10'd107;  8'd27: p = 10'd109;
         8'd28: p = 10'd113;  8'd29: p = 10'd127;  8'd30: p = 10'd131;  8'd31: p = 10'd137;
         8'd32: p = 10'd139;  8'd33: p = 10'd149;  8'd34: p = 10'd151;  8'd35: p = 10'd157;
         8'd36: p = 10'd163;  8'd37: p = 10'd167;  8'd38: p = 10'd173;  8'd39: p = 10'd179;
         8'd40: p = 10'd181;  8'd41: p = 10'd191;  8'd42: p = 10'd193;  8'd43: p = 10'd197;
         8'd44: p = 10'd199;  8'd45: p = 10'd211;  8'd46: p = 10'd223;  8'd47: p = 10'd227;
         8'd48: p = 10'd229;  8'd49: p = 10'd233;  8'd50: p = 10'd239;  8'd51: p = 10'd241;
         8'd52: p = 10'd251;  8'd53: p = 10'd257;  8'd54: p = 10'd263;  8'd55: p = 10'd269;
         8'd56: p = 10'd271;  8'd57: p = 10'd277;  8'd58: p = 10'd281;  8'd59: p = 10'd283;
         8'd60: p = 10'd293;  8'd61: p = 10'd307;  8'd62: p = 10'd311;  8'd63: p = 10'd313;
         8'd64: p = 10'd317;  8'd65: p = 10'd331;  8'd66: p = 10'd337;  8'd67: p = 10'd347;
         8'd68: p = 10'd349;  8'd69: p = 10'd353;  8'd70: p = 10'd359;  8'd71: p = 10'd367;
         8'd72: p = 10'd373;  8'd73: p = 10'd379;  8'd74: p = 10'd383;  8'd75: p = 10'd389;
         8'd76: p = 10'd397;  8'd77: p = 10'd401;  8'd78: p = 10'd409;  8'd79: p = 10'd419;
         8'd80: p = 10'd421;  8'd81: p = 10'd431;  8'd82: p = 10'd433;  8'd83: p = 10'd439;
         8'd84: p = 10'd443;  8'd85: p = 10'd449;  8'd86: p = 10'd457;  8'd87: p = 10'd461;
         8'd88: p = 10'd463;  8'd89: p = 10'd467;  8'd90: p = 10'd479;  8'd91: p = 10'd487;
         8'd92: p = 10'd491;  8'd93: p = 10'd499;  8'd94: p = 10'd503;  8'd95: p = 10'd509;
         8'd96: p = 10'd521;  8'd97: p = 10'd523;  8'd98: p = 10'd541;  8'd99: p = 10'd547;
         8'd100: p = 10'd557; 8'd101: p = 10'd563; 8'd102: p = 10'd569; 8'd103: p = 10'd571;
         8'd104: p = 10'd577; 8'd105: p = 10'd587; 8'd106: p = 10'd593; 8'd107: p = 10'd599;
         8'd108: p = 10'd601; 8'd109: p = 10'd607; 8'd110: p = 10'd613; 8'd111: p = 10'd617;
         8'd112: p = 10'd619; 8'd113: p = 10'd631; 8'd114: p = 10'd641; 8'd115: p = 10'd643;
         8'd116: p = 10'd647; 8'd117: p = 10'd653; 8'd118: p = 10'd659; 8'd119: p = 10'd661;
         8'd120: p = 10'd673; 8'd121: p = 10'd677; 8'd122: p = 10'd683; 8'd123: p = 10'd691;
         8'd124: p = 10'd701; 8'd125: p = 10'd709; 8'd126: p = 10'd719; 8'd127: p = 10'd727;
         8'd128: p = 10'd733; 8'd129: p = 10'd739; 8'd130: p = 10'd743; 8'd131: p = 10'd751;
         8'd132: p = 10'd757; 8'd133: p = 10'd761; 8'd134: p = 10'd769; 8'd135: p = 10'd773;
         8'd136: p = 10'd787; 8'd137: p = 10'd797; 8'd138: p = 10'd809; 8'd139: p = 10'd811;
         8'd140: p = 10'd821; 8'd141: p = 10'd823; 8'd142: p = 10'd827; 8'd143: p = 10'd829;
         8'd144: p = 10'd839; 8'd145: p = 10'd853; 8'd146: p = 10'd857; 8'd147: p = 10'd859;
         8'd148: p = 10'd863; 8'd149: p = 10'd877; 8'd150: p = 10'd881; 8'd151: p = 10'd883;
         8'd152: p = 10'd887; 8'd153: p = 10'd907; 8'd154: p = 10'd911; 8'd155: p = 10'd919;
         8'd156: p = 10'd929; 8'd157: p = 10'd937; 8'd158: p = 10'd941; 8'd159: p = 10'd947;
         8'd160: p = 10'd953; 8'd161: p = 10'd967; 8'd162: p = 10'd971; 8'd163: p = 10'd977;
         8'd164: p = 10'd983; 8'd165: p = 10'd991; 8'd166: p = 10'd997;
         default: p = 10'd3;
      endcase
      return p;
   endfunction

endpackage

FILE: rtl/miller_rabin_prime_test.sv
// Channel   Direction  Ports                          Payload
// request   in         req_valid / req_stall          req_candidate, req_witness
// response  out        rsp_valid / rsp_stall          rsp_verdict
//
// One request at a time. Trial division makes up to SMALL_PRIME_COUNT passes
// (at most the 167 table primes) on the bit-serial remainder unit; the
// Miller-Rabin round takes up to about 2*WIDTH modular products on the
// shared bit-serial multiplier. Values decided early skip the later steps.
// Reset is synchronous and clears the state and response-valid registers;
// the datapath is not reset. A stalled response holds; the next request
// is taken once the response has left.
module miller_rabin_prime_test #(
   parameter int WIDTH             = mr_pkg::WIDTH_DEFAULT,
   parameter int SMALL_PRIME_COUNT = mr_pkg::SMALL_PRIME_COUNT_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [63:0]      req_candidate,
   input  logic [63:0]      req_witness,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [1:0]       rsp_verdict
);
   import mr_pkg::*;

   localparam int EW = $clog2(WIDTH + 1);
   localparam int PRIMES = (SMALL_PRIME_COUNT < PRIME_TABLE_LEN) ?
                           SMALL_PRIME_COUNT : PRIME_TABLE_LEN;

   state_type state_ff, state_in;

   logic [WIDTH-1:0]       n_ff, n_in;
   logic [WIDTH-1:0]       a_ff, a_in;
   logic [WIDTH-1:0]       d_ff, d_in;
   logic [WIDTH-1:0]       x_ff, x_in;
   logic [WIDTH-1:0]       base_ff, base_in;
   logic [EW-1:0]          t_ff, t_in;
   logic [PRIME_IDX_W-1:0] pidx_ff, pidx_in;
   logic                   sq_phase_ff, sq_phase_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [1:0]             verdict_ff, verdict_in;

   mul_ctl_type      mul_ctl;
   logic [WIDTH-1:0] mul_a, mul_b;
   logic             mul_done;
   logic [WIDTH-1:0] mul_p;

   logic             trial_start;
   logic             trial_done;
   logic             trial_zero;
   logic [9:0]       prime;
   logic [WIDTH-1:0] n_m1;

   assign prime = odd_prime(pidx_ff);
   assign n_m1  = n_ff - 1'b1;

   mr_modmul #(.WIDTH(WIDTH)) u_mul (
      .clock   (clock),
      .reset   (reset),
      .ctl     (mul_ctl),
      .a       (mul_a),
      .b       (mul_b),
      .n       (n_ff),
      .done    (mul_done),
      .product (mul_p)
   );

   mr_trial #(.WIDTH(WIDTH)) u_trial (
      .clock (clock),
      .reset (reset),
      .start (trial_start),
      .n     (n_ff),
      .p     (prime),
      .done  (trial_done),
      .zero  (trial_zero)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff        <= n_in;
      a_ff        <= a_in;
      d_ff        <= d_in;
      x_ff        <= x_in;
      base_ff     <= base_in;
      t_ff        <= t_in;
      pidx_ff     <= pidx_in;
      sq_phase_ff <= sq_phase_in;
      verdict_ff  <= verdict_in;
   end

   always_comb begin
      state_in      = state_ff;
      n_in          = n_ff;
      a_in          = a_ff;
      d_in          = d_ff;
      x_in          = x_ff;
      base_in       = base_ff;
      t_in          = t_ff;
      pidx_in       = pidx_ff;
      sq_phase_in   = sq_phase_ff;
      rsp_valid_in  = rsp_valid_ff;
      verdict_in    = verdict_ff;
      mul_ctl.start = 1'b0;
      mul_a         = x_ff;
      mul_b         = x_ff;
      trial_start   = 1'b0;
      req_stall     = 1'b1;

      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               n_in     = req_candidate[WIDTH-1:0];
               a_in     = req_witness[WIDTH-1:0];
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            pidx_in = '0;
            if (n_ff == WIDTH'(2)) begin
               verdict_in = VERDICT_PRIME;
               state_in   = ST_DONE;
            end else if (n_ff < WIDTH'(3) || !n_ff[0]) begin
               verdict_in = VERDICT_COMPOSITE;
               state_in   = ST_DONE;
            end else if (PRIMES == 0) begin
               state_in = ST_SPLIT;
            end else begin
               state_in = ST_TRIAL_LOAD;
            end
            d_in = n_m1;
            t_in = '0;
         end
         ST_TRIAL_LOAD: begin
            if (n_ff == WIDTH'(prime)) begin
               verdict_in = VERDICT_PRIME;
               state_in   = ST_DONE;
            end else begin
               trial_start = 1'b1;
               state_in    = ST_TRIAL_RUN;
            end
         end
         ST_TRIAL_RUN: begin
            if (trial_done) begin
               state_in = ST_TRIAL_EVAL;
            end
         end
         ST_TRIAL_EVAL: begin
            if (trial_zero) begin
               verdict_in = VERDICT_COMPOSITE;
               state_in   = ST_DONE;
            end else if (32'(pidx_ff) == PRIMES - 1) begin
               state_in = ST_SPLIT;
            end else begin
               pidx_in  = pidx_ff + 1'b1;
               state_in = ST_TRIAL_LOAD;
            end
         end
         ST_SPLIT: begin
            // Reject a witness outside 2..n-1, else strip factors of two from n-1, one per cycle.
            if (a_ff < WIDTH'(2) || a_ff > n_m1) begin
               verdict_in = VERDICT_BAD_BASE;
               state_in   = ST_DONE;
            end else if (!d_ff[0]) begin
               d_in = {1'b0, d_ff[WIDTH-1:1]};
               t_in = t_ff + 1'b1;
            end else begin
               x_in     = WIDTH'(1);
               base_in  = a_ff;
               state_in = ST_POW_MUL;
            end
         end
         ST_POW_MUL: begin
            // Right-to-left exponentiation: multiply if the exponent bit is set.
            if (d_ff == '0) begin
               if (x_ff == WIDTH'(1) || x_ff == n_m1) begin
                  verdict_in = VERDICT_PROBABLE;
                  state_in   = ST_DONE;
               end else begin
                  t_in     = t_ff - 1'b1;
                  state_in = ST_SQ_CHECK;
               end
            end else if (d_ff[0]) begin
               mul_a         = x_ff;
               mul_b         = base_ff;
               mul_ctl.start = 1'b1;
               sq_phase_in   = 1'b0;
               state_in      = ST_POW_WAIT;
            end else begin
               state_in = ST_POW_SQ;
            end
         end
         ST_POW_SQ: begin
            mul_a         = base_ff;
            mul_b         = base_ff;
            mul_ctl.start = 1'b1;
            sq_phase_in   = 1'b1;
            state_in      = ST_POW_WAIT;
         end
         ST_POW_WAIT: begin
            // The multiplier reads its addend on every step.
            mul_a = sq_phase_ff ? base_ff : x_ff;
            if (mul_done) begin
               if (sq_phase_ff) begin
                  base_in  = mul_p;
                  d_in     = {1'b0, d_ff[WIDTH-1:1]};
                  state_in = ST_POW_MUL;
               end else begin
                  x_in     = mul_p;
                  state_in = ST_POW_SQ;
               end
            end
         end
         ST_SQ_CHECK: begin
            if (t_ff == '0) begin
               verdict_in = VERDICT_COMPOSITE;
               state_in   = ST_DONE;
            end else begin
               mul_a         = x_ff;
               mul_b         = x_ff;
               mul_ctl.start = 1'b1;
               state_in      = ST_SQ_WAIT;
            end
         end
         ST_SQ_WAIT: begin
            if (mul_done) begin
               x_in = mul_p;
               if (mul_p == n_m1) begin
                  verdict_in = VERDICT_PROBABLE;
                  state_in   = ST_DONE;
               end else begin
                  t_in     = t_ff - 1'b1;
                  state_in = ST_SQ_CHECK;
               end
            end
         end
         ST_DONE: begin
            rsp_valid_in = 1'b1;
            if (rsp_valid_ff && !rsp_stall) begin
               rsp_valid_in = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_verdict = verdict_ff;

   a_rsp_only_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == ST_DONE))
      else $error("response shown outside the done state");
   a_no_req_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> req_stall)
      else $error("request taken while busy");
   a_mul_done_waiting: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> (state_ff == ST_POW_WAIT || state_ff == ST_SQ_WAIT))
      else $error("product finished with no one waiting");
   a_odd_modulus: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_POW_WAIT || state_ff == ST_SQ_WAIT) |-> n_ff[0])
      else $error("modular product on an even modulus");

endmodule

FILE: rtl/mr_modmul.sv
// Bit-serial modular multiplier: one multiplier bit per cycle, MSB first.
module mr_modmul #(
   parameter int WIDTH = mr_pkg::WIDTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  mr_pkg::mul_ctl_type ctl,
   input  logic [WIDTH-1:0] a,
   input  logic [WIDTH-1:0] b,
   input  logic [WIDTH-1:0] n,
   output logic             done,
   output logic [WIDTH-1:0] product
);
   import mr_pkg::*;

   localparam int CW = $clog2(WIDTH + 1);

   logic [WIDTH-1:0] r_ff, r_in;
   logic [WIDTH-1:0] b_ff, b_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [WIDTH:0]   dbl;
   logic [WIDTH-1:0] dbl_red;
   logic [WIDTH:0]   sum;
   logic [WIDTH-1:0] sum_red;

   // r < n, so 2r < 2n and one subtract brings it back into range.
   always_comb begin
      dbl     = {r_ff, 1'b0};
      dbl_red = (dbl >= {1'b0, n}) ? WIDTH'(dbl - {1'b0, n}) : dbl[WIDTH-1:0];
      sum     = {1'b0, dbl_red} + {1'b0, a};
      sum_red = (sum >= {1'b0, n}) ? WIDTH'(sum - {1'b0, n}) : sum[WIDTH-1:0];
   end

   always_comb begin
      r_in    = r_ff;
      b_in    = b_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctl.start) begin
         r_in    = '0;
         b_in    = b;
         cnt_in  = CW'(WIDTH);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         r_in   = b_ff[WIDTH-1] ? sum_red : dbl_red;
         b_in   = {b_ff[WIDTH-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      r_ff <= r_in;
      b_ff <= b_in;
   end

   assign done    = done_ff;
   assign product = r_ff;

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("multiplier done without a running product");
   a_rem_in_range: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !ctl.start && n != '0 && r_ff < n) |=> (r_ff < $past(n)))
      else $error("partial remainder left the modulus range");
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !ctl.start)
      else $error("multiplier restarted while busy");

endmodule

FILE: rtl/mr_trial.sv
// Bit-serial remainder of n by a 10-bit divisor, one dividend bit per cycle.
module mr_trial #(
   parameter int WIDTH = mr_pkg::WIDTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] n,
   input  logic [9:0]       p,
   output logic             done,
   output logic             zero
);
   import mr_pkg::*;

   localparam int CW = $clog2(WIDTH + 1);

   logic [WIDTH-1:0] sh_ff, sh_in;
   logic [9:0]       rem_ff, rem_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [10:0]      t;

   always_comb begin
      t       = {rem_ff, sh_ff[WIDTH-1]};
      sh_in   = sh_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         sh_in   = n;
         rem_in  = '0;
         cnt_in  = CW'(WIDTH);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = (t >= {1'b0, p}) ? 10'(t - {1'b0, p}) : t[9:0];
         sh_in  = {sh_ff[WIDTH-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      sh_ff  <= sh_in;
      rem_ff <= rem_in;
   end

   assign done = done_ff;
   assign zero = (rem_ff == '0);

   a_rem_below_p: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !start && rem_ff < p) |=> (rem_ff < $past(p)))
      else $error("trial remainder reached the divisor");
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("trial done held for two cycles");

endmodule
